### hw/rtl/ebcr_pkg.sv
`timescale 1ns / 1ps

package ebcr_pkg;

  // Fraction bits of the Q2.14 normal.
  localparam int NORM_FRAC = 14;

  // Divider geometry: dividend, divisor and quotient widths.
  localparam int NUM_W = 52;
  localparam int DEN_W = 17;
  localparam int QUO_W = 36;

  // One divider stage per quotient bit.
  localparam int DIV_STAGES = QUO_W;

  // Stages before the divider (seven) plus stages after it (three).
  localparam int LATENCY = DIV_STAGES + 10;

  // Width of a rounded velocity correction and of the final sum.
  localparam int TERM_W = 40;
  localparam int SUM_W  = TERM_W + 1;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic               go;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
  } side_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'(32'sh7fffffff));
    lo = SUM_W'(signed'(32'sh80000000));
    if (v > hi) begin
      return 32'h7fffffff;
    end else if (v < lo) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

### hw/rtl/ebcr_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage. The quotient
// must fit in QUO_W bits, so the top dividend bits start below the divisor.
module ebcr_div (
  input  logic                         clk,
  input  logic [ebcr_pkg::NUM_W-1:0]   num,
  input  logic [ebcr_pkg::DEN_W-1:0]   den,
  output logic [ebcr_pkg::QUO_W-1:0]   quo
);

  localparam int QW = ebcr_pkg::QUO_W;
  localparam int DW = ebcr_pkg::DEN_W;
  localparam int NW = ebcr_pkg::NUM_W;
  localparam int WW = DW + QW;

  logic [WW-1:0] work     [0:QW-1];
  logic [DW-1:0] dv       [0:QW-1];
  logic [WW-1:0] stage_in [0:QW-1];
  logic [DW-1:0] den_in   [0:QW-1];

  // The first stage holds the leading dividend bits as its partial remainder.
  assign stage_in[0] = {{(DW - (NW - QW)){1'b0}}, num};
  assign den_in[0]   = den;

  genvar k;
  generate
    for (k = 1; k < QW; k++) begin : g_link
      assign stage_in[k] = work[k-1];
      assign den_in[k]   = dv[k-1];
    end

    for (k = 0; k < QW; k++) begin : g_stage
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_new;

      // Shift in the next dividend bit and try a subtract.
      assign trial   = stage_in[k][WW-1:QW-1];
      assign diff    = trial - {1'b0, den_in[k]};
      assign ge      = trial >= {1'b0, den_in[k]};
      assign rem_new = ge ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clk) begin
        work[k] <= {rem_new, stage_in[k][QW-2:0], ge};
        dv[k]   <= den_in[k];
      end
    end
  endgenerate

  assign quo = work[QW-1][QW-1:0];

endmodule

### hw/rtl/elastic_ball_collision_resolve.sv
`timescale 1ns / 1ps

// Two-ball elastic collision resolver, Q16.16 velocities and shifts,
// Q2.14 contact normal.
//
// Input channel: a contact beat is taken at each rising edge with start
// high and busy low. busy is always low, so one contact may enter every
// cycle and the sustained rate is one contact per clock.
// Output channel: done is high for exactly one cycle with the result
// fields; the result is taken at the edge that ends that cycle. There is
// no back pressure, so nothing ever waits inside the pipe.
// A contact passes seven stages ahead of the divider, 36 divider stages and
// three after. The depth is set by the bit-per-stage dividers that scale
// the normal impulse and the penetration split by the total mass.
// Reset clears every valid bit, so no result appears for contacts taken
// before reset. Contacts without a hit, with zero total mass or with the
// balls separating come out with the input velocities and zero shifts.
module elastic_ball_collision_resolve (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               has_collision,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [31:0] a_vel_x,
  input  logic signed [31:0] a_vel_y,
  input  logic signed [31:0] b_vel_x,
  input  logic signed [31:0] b_vel_y,
  input  logic        [15:0] mass_a,
  input  logic        [15:0] mass_b,
  input  logic        [30:0] penetration,
  output logic               done,
  output logic               resolved,
  output logic signed [31:0] new_a_vel_x,
  output logic signed [31:0] new_a_vel_y,
  output logic signed [31:0] new_b_vel_x,
  output logic signed [31:0] new_b_vel_y,
  output logic signed [31:0] a_shift_x,
  output logic signed [31:0] a_shift_y,
  output logic signed [31:0] b_shift_x,
  output logic signed [31:0] b_shift_y
);

  localparam int NF  = ebcr_pkg::NORM_FRAC;
  localparam int NW  = ebcr_pkg::NUM_W;
  localparam int QW  = ebcr_pkg::QUO_W;
  localparam int TW  = ebcr_pkg::TERM_W;
  localparam int SW  = ebcr_pkg::SUM_W;
  localparam int DS  = ebcr_pkg::DIV_STAGES;

  // The pipe never stalls.
  assign busy = 1'b0;

  // Stage 1: capture the contact beat.
  logic               s1_valid;
  logic               s1_hit;
  logic signed [15:0] s1_nx, s1_ny;
  logic signed [31:0] s1_avx, s1_avy, s1_bvx, s1_bvy;
  logic        [15:0] s1_ma, s1_mb;
  logic        [30:0] s1_pen;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_hit <= has_collision;
    s1_nx  <= normal_x;
    s1_ny  <= normal_y;
    s1_avx <= a_vel_x;
    s1_avy <= a_vel_y;
    s1_bvx <= b_vel_x;
    s1_bvy <= b_vel_y;
    s1_ma  <= mass_a;
    s1_mb  <= mass_b;
    s1_pen <= penetration;
  end

  // Stage 2: velocity-normal products, total mass, penetration products.
  logic               s2_valid;
  logic               s2_hit;
  logic signed [15:0] s2_nx, s2_ny;
  logic signed [31:0] s2_avx, s2_avy, s2_bvx, s2_bvy;
  logic        [15:0] s2_ma, s2_mb;
  logic        [16:0] s2_mt;
  logic signed [47:0] s2_pax, s2_pay, s2_pbx, s2_pby;
  logic        [46:0] s2_pen_mb, s2_pen_ma;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_hit    <= s1_hit;
    s2_nx     <= s1_nx;
    s2_ny     <= s1_ny;
    s2_avx    <= s1_avx;
    s2_avy    <= s1_avy;
    s2_bvx    <= s1_bvx;
    s2_bvy    <= s1_bvy;
    s2_ma     <= s1_ma;
    s2_mb     <= s1_mb;
    s2_mt     <= {1'b0, s1_ma} + {1'b0, s1_mb};
    s2_pax    <= 48'(s1_avx) * 48'(s1_nx);
    s2_pay    <= 48'(s1_avy) * 48'(s1_ny);
    s2_pbx    <= 48'(s1_bvx) * 48'(s1_nx);
    s2_pby    <= 48'(s1_bvy) * 48'(s1_ny);
    s2_pen_mb <= 47'(s1_pen) * 47'(s1_mb);
    s2_pen_ma <= 47'(s1_pen) * 47'(s1_ma);
  end

  // Stage 3: normal velocities and rounded split numerators.
  logic               s3_valid;
  logic               s3_hit;
  logic signed [15:0] s3_nx, s3_ny;
  logic signed [31:0] s3_avx, s3_avy, s3_bvx, s3_bvy;
  logic        [15:0] s3_ma, s3_mb;
  logic        [16:0] s3_mt;
  logic signed [48:0] s3_an, s3_bn;
  logic        [47:0] s3_sa_num, s3_sb_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_hit    <= s2_hit;
    s3_nx     <= s2_nx;
    s3_ny     <= s2_ny;
    s3_avx    <= s2_avx;
    s3_avy    <= s2_avy;
    s3_bvx    <= s2_bvx;
    s3_bvy    <= s2_bvy;
    s3_ma     <= s2_ma;
    s3_mb     <= s2_mb;
    s3_mt     <= s2_mt;
    s3_an     <= 49'(s2_pax) + 49'(s2_pay);
    s3_bn     <= 49'(s2_pbx) + 49'(s2_pby);
    s3_sa_num <= 48'(s2_pen_mb) + 48'(s2_mt[16:1]);
    s3_sb_num <= 48'(s2_pen_ma) + 48'(s2_mt[16:1]);
  end

  // Stage 4: relative normal velocity.
  logic               s4_valid;
  logic               s4_go;
  logic signed [15:0] s4_nx, s4_ny;
  logic signed [31:0] s4_avx, s4_avy, s4_bvx, s4_bvy;
  logic        [15:0] s4_ma, s4_mb;
  logic        [16:0] s4_mt;
  logic signed [49:0] s4_rel;
  logic        [47:0] s4_sa_num, s4_sb_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_go     <= s3_hit && (s3_mt != '0);
    s4_nx     <= s3_nx;
    s4_ny     <= s3_ny;
    s4_avx    <= s3_avx;
    s4_avy    <= s3_avy;
    s4_bvx    <= s3_bvx;
    s4_bvy    <= s3_bvy;
    s4_ma     <= s3_ma;
    s4_mb     <= s3_mb;
    s4_mt     <= s3_mt;
    s4_rel    <= 50'(s3_bn) - 50'(s3_an);
    s4_sa_num <= s3_sa_num;
    s4_sb_num <= s3_sb_num;
  end

  // Stage 5: approach test and the rounded Q.16 relative speed. A resolved
  // contact has rel <= 0, so only the magnitude is kept.
  logic signed [50:0] s4_rnd;
  assign s4_rnd = 51'(signed'(51'd1 << (NF - 1))) - 51'(s4_rel);

  logic               s5_valid;
  logic               s5_go;
  logic signed [15:0] s5_nx, s5_ny;
  logic signed [31:0] s5_avx, s5_avy, s5_bvx, s5_bvy;
  logic        [15:0] s5_ma, s5_mb;
  logic        [16:0] s5_mt;
  logic        [34:0] s5_r16;
  logic        [47:0] s5_sa_num, s5_sb_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_go     <= s4_go && (s4_rel[49] || (s4_rel == '0));
    s5_nx     <= s4_nx;
    s5_ny     <= s4_ny;
    s5_avx    <= s4_avx;
    s5_avy    <= s4_avy;
    s5_bvx    <= s4_bvx;
    s5_bvy    <= s4_bvy;
    s5_ma     <= s4_ma;
    s5_mb     <= s4_mb;
    s5_mt     <= s4_mt;
    s5_r16    <= s4_rnd[48:NF];
    s5_sa_num <= s4_sa_num;
    s5_sb_num <= s4_sb_num;
  end

  // Stage 6: impulse numerators, twice the other mass times the speed.
  logic               s6_valid;
  logic               s6_go;
  logic signed [15:0] s6_nx, s6_ny;
  logic signed [31:0] s6_avx, s6_avy, s6_bvx, s6_bvy;
  logic        [16:0] s6_mt;
  logic        [51:0] s6_pa, s6_pb;
  logic        [47:0] s6_sa_num, s6_sb_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_go     <= s5_go;
    s6_nx     <= s5_nx;
    s6_ny     <= s5_ny;
    s6_avx    <= s5_avx;
    s6_avy    <= s5_avy;
    s6_bvx    <= s5_bvx;
    s6_bvy    <= s5_bvy;
    s6_mt     <= s5_mt;
    s6_pa     <= 52'(s5_r16) * 52'({s5_mb, 1'b0});
    s6_pb     <= 52'(s5_r16) * 52'({s5_ma, 1'b0});
    s6_sa_num <= s5_sa_num;
    s6_sb_num <= s5_sb_num;
  end

  // Stage 7: add half the divisor to impulse numerators to round to nearest.
  logic                s7_valid;
  ebcr_pkg::side_t     s7_side;
  logic        [16:0]  s7_mt;
  logic        [NW-1:0] s7_na, s7_nb, s7_nsa, s7_nsb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_side.go  <= s6_go;
    s7_side.nx  <= s6_nx;
    s7_side.ny  <= s6_ny;
    s7_side.avx <= s6_avx;
    s7_side.avy <= s6_avy;
    s7_side.bvx <= s6_bvx;
    s7_side.bvy <= s6_bvy;
    s7_mt       <= s6_mt;
    s7_na       <= s6_pa + NW'(s6_mt[16:1]);
    s7_nb       <= s6_pb + NW'(s6_mt[16:1]);
    s7_nsa      <= NW'(s6_sa_num);
    s7_nsb      <= NW'(s6_sb_num);
  end

  // Four dividers by the total mass, with the side data delayed to match.
  logic [QW-1:0] q_a, q_b, q_sa, q_sb;

  ebcr_div u_div_a  (.clk(clk), .num(s7_na),  .den(s7_mt), .quo(q_a));
  ebcr_div u_div_b  (.clk(clk), .num(s7_nb),  .den(s7_mt), .quo(q_b));
  ebcr_div u_div_sa (.clk(clk), .num(s7_nsa), .den(s7_mt), .quo(q_sa));
  ebcr_div u_div_sb (.clk(clk), .num(s7_nsb), .den(s7_mt), .quo(q_sb));

  logic            vld_line  [0:DS-1];
  ebcr_pkg::side_t side_line [0:DS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DS; i++) begin
        vld_line[i] <= 1'b0;
      end
    end else begin
      vld_line[0] <= s7_valid;
      for (int i = 1; i < DS; i++) begin
        vld_line[i] <= vld_line[i-1];
      end
    end
    side_line[0] <= s7_side;
    for (int i = 1; i < DS; i++) begin
      side_line[i] <= side_line[i-1];
    end
  end

  logic            dq_valid;
  ebcr_pkg::side_t dq_side;
  assign dq_valid = vld_line[DS-1];
  assign dq_side  = side_line[DS-1];

  // Stage 8: scale each quotient by the normal components.
  localparam int PW = 16 + QW + 1;

  logic              s8_valid;
  ebcr_pkg::side_t   s8_side;
  logic signed [PW-1:0] s8_pax, s8_pay, s8_pbx, s8_pby;
  logic signed [PW-1:0] s8_psax, s8_psay, s8_psbx, s8_psby;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= dq_valid;
    end
    s8_side <= dq_side;
    s8_pax  <= PW'(dq_side.nx) * PW'(signed'({1'b0, q_a}));
    s8_pay  <= PW'(dq_side.ny) * PW'(signed'({1'b0, q_a}));
    s8_pbx  <= PW'(dq_side.nx) * PW'(signed'({1'b0, q_b}));
    s8_pby  <= PW'(dq_side.ny) * PW'(signed'({1'b0, q_b}));
    s8_psax <= PW'(dq_side.nx) * PW'(signed'({1'b0, q_sa}));
    s8_psay <= PW'(dq_side.ny) * PW'(signed'({1'b0, q_sa}));
    s8_psbx <= PW'(dq_side.nx) * PW'(signed'({1'b0, q_sb}));
    s8_psby <= PW'(dq_side.ny) * PW'(signed'({1'b0, q_sb}));
  end

  // Round a product back from Q2.14 to nearest, ties away from zero.
  function automatic logic signed [TW-1:0] rnd14(input logic signed [PW-1:0] p);
    logic signed [PW:0] s;
    logic signed [PW:0] bias;
    bias = p[PW-1] ? (PW+1)'((1 << (NF - 1)) - 1) : (PW+1)'(1 << (NF - 1));
    s    = (PW+1)'(p) + bias;
    return s[PW:NF];
  endfunction

  // Stage 9: rounded corrections.
  logic                 s9_valid;
  ebcr_pkg::side_t      s9_side;
  logic signed [TW-1:0] s9_tax, s9_tay, s9_tbx, s9_tby;
  logic signed [TW-1:0] s9_tsax, s9_tsay, s9_tsbx, s9_tsby;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else begin
      s9_valid <= s8_valid;
    end
    s9_side <= s8_side;
    s9_tax  <= rnd14(s8_pax);
    s9_tay  <= rnd14(s8_pay);
    s9_tbx  <= rnd14(s8_pbx);
    s9_tby  <= rnd14(s8_pby);
    s9_tsax <= rnd14(s8_psax);
    s9_tsay <= rnd14(s8_psay);
    s9_tsbx <= rnd14(s8_psbx);
    s9_tsby <= rnd14(s8_psby);
  end

  // Stage 10: apply corrections with saturation, or pass the contact through.
  // Ball A's impulse is negative along the normal and it shifts against it.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s9_valid;
    end
    resolved <= s9_side.go;
    if (s9_side.go) begin
      new_a_vel_x <= ebcr_pkg::sat32(SW'(s9_side.avx) - SW'(s9_tax));
      new_a_vel_y <= ebcr_pkg::sat32(SW'(s9_side.avy) - SW'(s9_tay));
      new_b_vel_x <= ebcr_pkg::sat32(SW'(s9_side.bvx) + SW'(s9_tbx));
      new_b_vel_y <= ebcr_pkg::sat32(SW'(s9_side.bvy) + SW'(s9_tby));
      a_shift_x   <= ebcr_pkg::sat32(-SW'(s9_tsax));
      a_shift_y   <= ebcr_pkg::sat32(-SW'(s9_tsay));
      b_shift_x   <= ebcr_pkg::sat32(SW'(s9_tsbx));
      b_shift_y   <= ebcr_pkg::sat32(SW'(s9_tsby));
    end else begin
      new_a_vel_x <= s9_side.avx;
      new_a_vel_y <= s9_side.avy;
      new_b_vel_x <= s9_side.bvx;
      new_b_vel_y <= s9_side.bvy;
      a_shift_x   <= '0;
      a_shift_y   <= '0;
      b_shift_x   <= '0;
      b_shift_y   <= '0;
    end
  end

endmodule

### hw/rtl/ebcr_chk.sv
`timescale 1ns / 1ps

// Port-level checks for the collision resolver.
module ebcr_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               has_collision,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [31:0] a_vel_x,
  input logic signed [31:0] a_vel_y,
  input logic signed [31:0] b_vel_x,
  input logic signed [31:0] b_vel_y,
  input logic        [15:0] mass_a,
  input logic        [15:0] mass_b,
  input logic        [30:0] penetration,
  input logic               done,
  input logic               resolved,
  input logic signed [31:0] new_a_vel_x,
  input logic signed [31:0] new_a_vel_y,
  input logic signed [31:0] new_b_vel_x,
  input logic signed [31:0] new_b_vel_y,
  input logic signed [31:0] a_shift_x,
  input logic signed [31:0] a_shift_y,
  input logic signed [31:0] b_shift_x,
  input logic signed [31:0] b_shift_y
);

  localparam int LAT = ebcr_pkg::LATENCY;

  // Every accepted contact yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted contact produced no result");

  // No result appears without a contact taken that many cycles earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching contact");

  // An unresolved contact passes its velocities through unchanged.
  a_pass_vel: assert property (@(posedge clk) disable iff (rst)
    (done && !resolved) |->
      (new_a_vel_x == $past(a_vel_x, LAT)) && (new_a_vel_y == $past(a_vel_y, LAT)) &&
      (new_b_vel_x == $past(b_vel_x, LAT)) && (new_b_vel_y == $past(b_vel_y, LAT)))
    else $error("unresolved contact changed a velocity");

  // An unresolved contact has zero shifts; a contact without a hit is unresolved.
  a_pass_shift: assert property (@(posedge clk) disable iff (rst)
    (done && (!resolved || !$past(has_collision, LAT))) |->
      !resolved && (a_shift_x == 0) && (a_shift_y == 0) &&
      (b_shift_x == 0) && (b_shift_y == 0))
    else $error("unresolved contact gave a shift");

endmodule

bind elastic_ball_collision_resolve ebcr_chk u_ebcr_chk (.*);
